// ===== sv/krt_pkg.sv =====
// shared types, constants and name canonicalization for the record table
package krt_pkg;

    localparam int DEPTH      = 64;
    localparam int NAME_BYTES = 30;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int NAME_W     = 256;
    localparam int AGE_W      = 7;
    localparam int SAL_W      = 32;

    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_FIND    = 3'd1;
    localparam logic [2:0] REQ_REPLACE = 3'd2;
    localparam logic [2:0] REQ_DELETE  = 3'd3;
    localparam logic [2:0] REQ_SORT    = 3'd4;
    localparam logic [2:0] REQ_LIST    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [AGE_W-1:0]  age;
        logic [SAL_W-1:0]  salary;
    } rec_t;

    // keep at most NAME_BYTES-1 bytes, zero everything from the first zero byte
    function automatic logic [NAME_W-1:0] canon(input logic [NAME_W-1:0] src);
        logic [NAME_W-1:0] dst;
        logic              ended;
        logic [7:0]        byte_v;
        dst   = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++) begin
            byte_v = src[NAME_W-1-8*b -: 8];
            if (b >= NAME_BYTES - 1 || byte_v == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                dst[NAME_W-1-8*b -: 8] = byte_v;
            end
        end
        return dst;
    endfunction

endpackage

// ===== sv/krt_ram.sv =====
// record memory: one write port, one registered read port
module krt_ram (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [krt_pkg::ADDR_W-1:0] waddr,
    input  krt_pkg::rec_t         wdata,
    input  logic                  re,
    input  logic [krt_pkg::ADDR_W-1:0] raddr,
    output krt_pkg::rec_t         rdata
);
    import krt_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/keyed_record_table_sort_search.sv =====
// Keyed record table: records live in one RAM with a registered read
// port and one write port; a sequencer walks the table for every request. Each
// memory access is a read state followed by a use state, so the cost is set by
// that single read port: find/replace scan entries up to the hit, delete also
// moves every later entry up, list reads every entry, and sort compares each
// entry with every later one. One request is worked at a time; the next
// is taken once the previous request has finished its table walk (for delete,
// this includes moving the later entries up) and its last word sits in the
// output register. Names are canonicalized on entry (bytes after the first
// zero, and from byte NAME_BYTES-1 on, read as zero) so a plain 256-bit compare
// matches string order. Unknown request types are taken and dropped with no
// word out.
module keyed_record_table_sort_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [63:0] s_key_w0,
    input  logic [63:0] s_key_w1,
    input  logic [63:0] s_key_w2,
    input  logic [63:0] s_key_w3,
    input  logic [63:0] s_new_w0,
    input  logic [63:0] s_new_w1,
    input  logic [63:0] s_new_w2,
    input  logic [63:0] s_new_w3,
    input  logic [6:0]  s_new_age,
    input  logic [31:0] s_new_salary,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_rec_w0,
    output logic [63:0] m_rec_w1,
    output logic [63:0] m_rec_w2,
    output logic [63:0] m_rec_w3,
    output logic [6:0]  m_rec_age,
    output logic [31:0] m_rec_salary,
    output logic        m_is_last
);
    import krt_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISP      = 4'd1;
    localparam logic [3:0] S_SCAN_RD   = 4'd2;
    localparam logic [3:0] S_SCAN_CMP  = 4'd3;
    localparam logic [3:0] S_DEL_RD    = 4'd4;
    localparam logic [3:0] S_DEL_WR    = 4'd5;
    localparam logic [3:0] S_SORT_LI   = 4'd6;
    localparam logic [3:0] S_SORT_HI   = 4'd7;
    localparam logic [3:0] S_SORT_RJ   = 4'd8;
    localparam logic [3:0] S_SORT_CJ   = 4'd9;
    localparam logic [3:0] S_SORT_WI   = 4'd10;
    localparam logic [3:0] S_SORT_DONE = 4'd11;
    localparam logic [3:0] S_LIST_RD   = 4'd12;
    localparam logic [3:0] S_LIST_EM   = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        req_reg, req_next;
    logic [NAME_W-1:0] key_reg, key_next;
    rec_t              nrec_reg, nrec_next;
    rec_t              held_reg, held_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] jdx_reg, jdx_next;

    // output word register
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg, status_next;
    rec_t              orec_reg, orec_next;
    logic              last_reg, last_next;

    // ram port
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    rec_t              wdata, rdata;

    // word to emit this cycle
    logic              emit;
    logic [1:0]        em_status;
    rec_t              em_rec;
    logic              em_last;

    logic              out_free;
    logic [CNT_W-1:0]  idx_p1, jdx_p1;

    krt_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign idx_p1   = CNT_W'(idx_reg) + CNT_W'(1);
    assign jdx_p1   = CNT_W'(jdx_reg) + CNT_W'(1);
    assign s_ready  = (state_reg == S_IDLE);

    // accesses are strictly read-then-use, so no write ever meets a read of
    // the same entry in one cycle
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        nrec_next  = nrec_reg;
        held_next  = held_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = held_reg;
        re         = 1'b0;
        raddr      = idx_reg;
        emit       = 1'b0;
        em_status  = ST_OK;
        em_rec     = '0;
        em_last    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_req_type <= REQ_LIST) begin
                    req_next         = s_req_type;
                    key_next         = canon({s_key_w0, s_key_w1, s_key_w2, s_key_w3});
                    nrec_next.name   = canon({s_new_w0, s_new_w1, s_new_w2, s_new_w3});
                    nrec_next.age    = s_new_age;
                    nrec_next.salary = s_new_salary;
                    state_next       = S_DISP;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    idx_next = '0;
                    if (req_reg == REQ_APPEND) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (count_reg == CNT_W'(DEPTH)) begin
                            em_status = ST_FULL;
                        end else begin
                            we         = 1'b1;
                            waddr      = count_reg[ADDR_W-1:0];
                            wdata      = nrec_reg;
                            em_rec     = nrec_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        emit       = 1'b1;
                        em_status  = ST_EMPTY;
                        state_next = S_IDLE;
                    end else if (req_reg == REQ_SORT) begin
                        if (count_reg == CNT_W'(1)) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_SORT_LI;
                        end
                    end else if (req_reg == REQ_LIST) begin
                        state_next = S_LIST_RD;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                re         = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (rdata.name == key_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        em_rec     = rdata;
                        state_next = S_IDLE;
                        if (req_reg == REQ_REPLACE) begin
                            we     = 1'b1;
                            wdata  = nrec_reg;
                            em_rec = nrec_reg;
                        end else if (req_reg == REQ_DELETE) begin
                            if (idx_p1 < count_reg) begin
                                idx_next   = idx_p1[ADDR_W-1:0];
                                state_next = S_DEL_RD;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                end else if (idx_p1 == count_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        em_status  = ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                end else begin
                    idx_next   = idx_p1[ADDR_W-1:0];
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD: begin
                re         = 1'b1;
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                // move entry up one place
                we    = 1'b1;
                waddr = idx_reg - ADDR_W'(1);
                wdata = rdata;
                if (idx_p1 < count_reg) begin
                    idx_next   = idx_p1[ADDR_W-1:0];
                    state_next = S_DEL_RD;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_SORT_LI: begin
                re         = 1'b1;
                state_next = S_SORT_HI;
            end
            S_SORT_HI: begin
                // holds entry i, then the smallest name seen in the pass
                held_next  = rdata;
                jdx_next   = idx_p1[ADDR_W-1:0];
                state_next = S_SORT_RJ;
            end
            S_SORT_RJ: begin
                re         = 1'b1;
                raddr      = jdx_reg;
                state_next = S_SORT_CJ;
            end
            S_SORT_CJ: begin
                if (held_reg.name > rdata.name) begin
                    we        = 1'b1;
                    waddr     = jdx_reg;
                    wdata     = held_reg;
                    held_next = rdata;
                end
                if (jdx_p1 < count_reg) begin
                    jdx_next   = jdx_p1[ADDR_W-1:0];
                    state_next = S_SORT_RJ;
                end else begin
                    state_next = S_SORT_WI;
                end
            end
            S_SORT_WI: begin
                we    = 1'b1;
                wdata = held_reg;
                if (idx_p1 < count_reg - CNT_W'(1)) begin
                    idx_next   = idx_p1[ADDR_W-1:0];
                    state_next = S_SORT_LI;
                end else begin
                    state_next = S_SORT_DONE;
                end
            end
            S_SORT_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD: begin
                re         = 1'b1;
                state_next = S_LIST_EM;
            end
            S_LIST_EM: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_rec  = rdata;
                    em_last = (idx_p1 == count_reg);
                    if (idx_p1 == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_p1[ADDR_W-1:0];
                        state_next = S_LIST_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: load on emit, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        orec_next    = orec_reg;
        last_next    = last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            status_next  = em_status;
            orec_next    = em_rec;
            last_next    = em_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        key_reg    <= key_next;
        nrec_reg   <= nrec_next;
        held_reg   <= held_next;
        idx_reg    <= idx_next;
        jdx_reg    <= jdx_next;
        status_reg <= status_next;
        orec_reg   <= orec_next;
        last_reg   <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_rec_w0     = orec_reg.name[255:192];
    assign m_rec_w1     = orec_reg.name[191:128];
    assign m_rec_w2     = orec_reg.name[127:64];
    assign m_rec_w3     = orec_reg.name[63:0];
    assign m_rec_age    = orec_reg.age;
    assign m_rec_salary = orec_reg.salary;
    assign m_is_last    = last_reg;

endmodule

// ===== sv/krt_checker.sv =====
// port-level checks for the record table, bound to the top level
module krt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_req_type,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [6:0]  m_rec_age,
    input logic [31:0] m_rec_salary,
    input logic        m_is_last
);
    import krt_pkg::*;

    // a real request closes the input side until it is worked
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type <= REQ_LIST |=> !s_ready)
        else $error("input taken again right after a request");

    // error status ends the request
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_is_last)
        else $error("error word not marked last");

    // error words carry no record
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_rec_age == '0 && m_rec_salary == '0)
        else $error("error word carries record data");

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_is_last))
        else $error("stalled output word changed");

endmodule

bind keyed_record_table_sort_search krt_checker u_krt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_req_type   (s_req_type),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_rec_age    (m_rec_age),
    .m_rec_salary (m_rec_salary),
    .m_is_last    (m_is_last)
);
